// File: design/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg
// Shared constants for the quaternion to rotation matrix pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package qrm_pkg;

    localparam int DEFAULT_COMPONENT_WIDTH = 16;
    localparam int DEFAULT_FRACTION_BITS   = 14;

    localparam int LANES    = 9;
    localparam int PRODUCTS = 10;

    localparam int P_XX = 0;
    localparam int P_YY = 1;
    localparam int P_ZZ = 2;
    localparam int P_WW = 3;
    localparam int P_XY = 4;
    localparam int P_XZ = 5;
    localparam int P_YZ = 6;
    localparam int P_WX = 7;
    localparam int P_WY = 8;
    localparam int P_WZ = 9;

    localparam int L_R00 = 0;
    localparam int L_R01 = 1;
    localparam int L_R02 = 2;
    localparam int L_R10 = 3;
    localparam int L_R11 = 4;
    localparam int L_R12 = 5;
    localparam int L_R20 = 6;
    localparam int L_R21 = 7;
    localparam int L_R22 = 8;

endpackage
`default_nettype wire

// File: design/quaternion_to_rotation_matrix_unit.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_unit
// Normalized quaternion to 3x3 rotation matrix, fixed point, fully pipelined.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake           Word
//   s_        in         s_valid / s_ready   qx, qy, qz, qw
//   m_        out        m_valid / m_ready   r00 .. r22, zero_input
//
// One word enters per cycle unless m_ready holds the pipeline. The stages are one
// product stage, one numerator stage, FRACTION_BITS + 2 restoring division steps
// (one quotient bit per stage in nine lanes), and one rounding stage.
// Reset clears only the stage valid bits. Each stage holds its word while the
// next stage is full and stalled, so a stall loses or repeats nothing.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_to_rotation_matrix_unit #(
    parameter int COMPONENT_WIDTH = qrm_pkg::DEFAULT_COMPONENT_WIDTH,
    parameter int FRACTION_BITS   = qrm_pkg::DEFAULT_FRACTION_BITS
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic signed [COMPONENT_WIDTH-1:0] s_qx,
    input  wire logic signed [COMPONENT_WIDTH-1:0] s_qy,
    input  wire logic signed [COMPONENT_WIDTH-1:0] s_qz,
    input  wire logic signed [COMPONENT_WIDTH-1:0] s_qw,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic signed [COMPONENT_WIDTH-1:0]      m_r00,
    output logic signed [COMPONENT_WIDTH-1:0]      m_r01,
    output logic signed [COMPONENT_WIDTH-1:0]      m_r02,
    output logic signed [COMPONENT_WIDTH-1:0]      m_r10,
    output logic signed [COMPONENT_WIDTH-1:0]      m_r11,
    output logic signed [COMPONENT_WIDTH-1:0]      m_r12,
    output logic signed [COMPONENT_WIDTH-1:0]      m_r20,
    output logic signed [COMPONENT_WIDTH-1:0]      m_r21,
    output logic signed [COMPONENT_WIDTH-1:0]      m_r22,
    output logic                                   m_zero_input
);
    import qrm_pkg::*;

    localparam int W  = COMPONENT_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int SW = 2*W+2;
    localparam int QW = F+2;
    localparam logic signed [W-1:0] ONE_E = W'(1) << F;

    logic                      mul_valid, mul_ready;
    logic [PRODUCTS-1:0][2*W-1:0] prod;

    logic                      dv [QW+1];
    logic                      dr [QW+1];
    logic [SW-1:0]             dlen [QW+1];
    logic [LANES-1:0][SW-1:0]  drem [QW+1];
    logic [LANES-1:0][QW-1:0]  dq [QW+1];
    logic [LANES-1:0]          dneg [QW+1];
    logic                      dzero [QW+1];

    logic [LANES-1:0][W-1:0]   elem;

    qrm_mul #(.W(W)) u_mul (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_valid), .in_ready(s_ready),
        .qx(s_qx), .qy(s_qy), .qz(s_qz), .qw(s_qw),
        .out_valid(mul_valid), .out_ready(mul_ready), .prod(prod)
    );

    qrm_numer #(.W(W)) u_numer (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(mul_valid), .in_ready(mul_ready), .prod(prod),
        .out_valid(dv[0]), .out_ready(dr[0]),
        .len(dlen[0]), .mag(drem[0]), .neg(dneg[0]), .zero(dzero[0])
    );

    assign dq[0] = '0;

    for (genvar i = 0; i < QW; i++) begin : g_div
        qrm_div_step #(.W(W), .QW(QW), .SHIFT(i != 0)) u_step (
            .aclk(aclk), .aresetn(aresetn),
            .in_valid(dv[i]), .in_ready(dr[i]),
            .len_in(dlen[i]), .rem_in(drem[i]), .q_in(dq[i]),
            .neg_in(dneg[i]), .zero_in(dzero[i]),
            .out_valid(dv[i+1]), .out_ready(dr[i+1]),
            .len_out(dlen[i+1]), .rem_out(drem[i+1]), .q_out(dq[i+1]),
            .neg_out(dneg[i+1]), .zero_out(dzero[i+1])
        );
    end

    qrm_round #(.W(W), .F(F), .QW(QW)) u_round (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(dv[QW]), .in_ready(dr[QW]),
        .q_in(dq[QW]), .neg_in(dneg[QW]), .zero_in(dzero[QW]),
        .out_valid(m_valid), .out_ready(m_ready),
        .elem(elem), .zero(m_zero_input)
    );

    assign m_r00 = elem[L_R00];
    assign m_r01 = elem[L_R01];
    assign m_r02 = elem[L_R02];
    assign m_r10 = elem[L_R10];
    assign m_r11 = elem[L_R11];
    assign m_r12 = elem[L_R12];
    assign m_r20 = elem[L_R20];
    assign m_r21 = elem[L_R21];
    assign m_r22 = elem[L_R22];

    a_empty_out_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled while the output stage is empty");

    a_zero_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_zero_input |-> m_r00 == ONE_E && m_r11 == ONE_E
            && m_r22 == ONE_E && m_r01 == '0 && m_r12 == '0 && m_r20 == '0)
        else $error("zero quaternion did not give the identity");

    a_elem_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_r00 <= ONE_E && m_r00 >= -ONE_E
            && m_r12 <= ONE_E && m_r12 >= -ONE_E)
        else $error("matrix element outside plus or minus one");

endmodule
`default_nettype wire

// File: design/qrm_mul.sv
// ----------------------------------------------------------------------------
// qrm_mul
// First stage: the ten component products of the quaternion.
// ----------------------------------------------------------------------------
`default_nettype none
module qrm_mul #(
    parameter int W = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic signed [W-1:0]  qx,
    input  wire logic signed [W-1:0]  qy,
    input  wire logic signed [W-1:0]  qz,
    input  wire logic signed [W-1:0]  qw,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [qrm_pkg::PRODUCTS-1:0][2*W-1:0] prod
);
    import qrm_pkg::*;

    logic                             valid_reg;
    logic [PRODUCTS-1:0][2*W-1:0]     prod_reg;
    logic [PRODUCTS-1:0][2*W-1:0]     prod_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign prod      = prod_reg;

    always_comb begin
        prod_next[P_XX] = (2*W)'(qx * qx);
        prod_next[P_YY] = (2*W)'(qy * qy);
        prod_next[P_ZZ] = (2*W)'(qz * qz);
        prod_next[P_WW] = (2*W)'(qw * qw);
        prod_next[P_XY] = (2*W)'(qx * qy);
        prod_next[P_XZ] = (2*W)'(qx * qz);
        prod_next[P_YZ] = (2*W)'(qy * qz);
        prod_next[P_WX] = (2*W)'(qw * qx);
        prod_next[P_WY] = (2*W)'(qw * qy);
        prod_next[P_WZ] = (2*W)'(qw * qz);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            prod_reg <= prod_next;
        end
    end

endmodule
`default_nettype wire

// File: design/qrm_numer.sv
// ----------------------------------------------------------------------------
// qrm_numer
// Second stage: squared length, zero detect, and the nine signed numerators.
// ----------------------------------------------------------------------------
`default_nettype none
module qrm_numer #(
    parameter int W = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [qrm_pkg::PRODUCTS-1:0][2*W-1:0] prod,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2*W+1:0]            len,
    output logic [qrm_pkg::LANES-1:0][2*W+1:0] mag,
    output logic [qrm_pkg::LANES-1:0] neg,
    output logic                      zero
);
    import qrm_pkg::*;

    localparam int SW = 2*W+2;

    logic                          valid_reg;
    logic [SW-1:0]                 len_reg, len_next;
    logic [LANES-1:0][SW-1:0]      mag_reg, mag_next;
    logic [LANES-1:0]              neg_reg, neg_next;
    logic                          zero_reg, zero_next;
    logic signed [SW-1:0]          p [PRODUCTS];
    logic signed [SW-1:0]          d [LANES];

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign len       = len_reg;
    assign mag       = mag_reg;
    assign neg       = neg_reg;
    assign zero      = zero_reg;

    always_comb begin
        for (int i = 0; i < PRODUCTS; i++) begin
            p[i] = SW'($signed(prod[i]));
        end
        len_next  = SW'(p[P_XX] + p[P_YY] + p[P_ZZ] + p[P_WW]);
        zero_next = (len_next == '0);
        d[L_R00] = (p[P_XX] + p[P_WW]) - (p[P_YY] + p[P_ZZ]);
        d[L_R11] = (p[P_YY] + p[P_WW]) - (p[P_XX] + p[P_ZZ]);
        d[L_R22] = (p[P_ZZ] + p[P_WW]) - (p[P_XX] + p[P_YY]);
        d[L_R01] = (p[P_XY] - p[P_WZ]) <<< 1;
        d[L_R02] = (p[P_XZ] + p[P_WY]) <<< 1;
        d[L_R10] = (p[P_XY] + p[P_WZ]) <<< 1;
        d[L_R12] = (p[P_YZ] - p[P_WX]) <<< 1;
        d[L_R20] = (p[P_XZ] - p[P_WY]) <<< 1;
        d[L_R21] = (p[P_YZ] + p[P_WX]) <<< 1;
        for (int l = 0; l < LANES; l++) begin
            neg_next[l] = d[l][SW-1];
            mag_next[l] = neg_next[l] ? SW'(-d[l]) : SW'(d[l]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            len_reg  <= len_next;
            mag_reg  <= mag_next;
            neg_reg  <= neg_next;
            zero_reg <= zero_next;
        end
    end

endmodule
`default_nettype wire

// File: design/qrm_div_step.sv
// ----------------------------------------------------------------------------
// qrm_div_step
// One restoring division step for all nine lanes, one quotient bit each.
// ----------------------------------------------------------------------------
`default_nettype none
module qrm_div_step #(
    parameter int W     = 16,
    parameter int QW    = 16,
    parameter bit SHIFT = 1'b1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [2*W+1:0]       len_in,
    input  wire logic [qrm_pkg::LANES-1:0][2*W+1:0] rem_in,
    input  wire logic [qrm_pkg::LANES-1:0][QW-1:0]  q_in,
    input  wire logic [qrm_pkg::LANES-1:0] neg_in,
    input  wire logic                 zero_in,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [2*W+1:0]            len_out,
    output logic [qrm_pkg::LANES-1:0][2*W+1:0] rem_out,
    output logic [qrm_pkg::LANES-1:0][QW-1:0]  q_out,
    output logic [qrm_pkg::LANES-1:0] neg_out,
    output logic                      zero_out
);
    import qrm_pkg::*;

    localparam int SW = 2*W+2;

    logic                      valid_reg;
    logic [SW-1:0]             len_reg;
    logic [LANES-1:0][SW-1:0]  rem_reg, rem_next;
    logic [LANES-1:0][QW-1:0]  q_reg, q_next;
    logic [LANES-1:0]          neg_reg;
    logic                      zero_reg;
    logic [SW-1:0]             rem_sh [LANES];
    logic [LANES-1:0]          ge;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign len_out   = len_reg;
    assign rem_out   = rem_reg;
    assign q_out     = q_reg;
    assign neg_out   = neg_reg;
    assign zero_out  = zero_reg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            rem_sh[l]   = SHIFT ? {rem_in[l][SW-2:0], 1'b0} : rem_in[l];
            ge[l]       = (rem_sh[l] >= len_in);
            rem_next[l] = ge[l] ? rem_sh[l] - len_in : rem_sh[l];
            q_next[l]   = {q_in[l][QW-2:0], ge[l]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            len_reg  <= len_in;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            neg_reg  <= neg_in;
            zero_reg <= zero_in;
        end
    end

endmodule
`default_nettype wire

// File: design/qrm_round.sv
// ----------------------------------------------------------------------------
// qrm_round
// Last stage: rounding, clamping, sign, and the identity for a zero input.
// ----------------------------------------------------------------------------
`default_nettype none
module qrm_round #(
    parameter int W  = 16,
    parameter int F  = 14,
    parameter int QW = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [qrm_pkg::LANES-1:0][QW-1:0] q_in,
    input  wire logic [qrm_pkg::LANES-1:0] neg_in,
    input  wire logic                 zero_in,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [qrm_pkg::LANES-1:0][W-1:0] elem,
    output logic                      zero
);
    import qrm_pkg::*;

    localparam logic [QW-1:0] ONE_Q = QW'(1) << F;

    logic                     valid_reg;
    logic [LANES-1:0][W-1:0]  elem_reg, elem_next;
    logic                     zero_reg;
    logic [QW:0]              inc [LANES];
    logic [QW-1:0]            rq [LANES];
    logic [W-1:0]             v [LANES];

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign elem      = elem_reg;
    assign zero      = zero_reg;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            inc[l] = {1'b0, q_in[l]} + (QW+1)'(1);
            rq[l]  = inc[l][QW:1];
            if (rq[l] > ONE_Q) begin
                rq[l] = ONE_Q;
            end
            v[l] = W'(rq[l]);
            elem_next[l] = neg_in[l] ? W'(-v[l]) : v[l];
            if (zero_in) begin
                elem_next[l] = '0;
            end
        end
        if (zero_in) begin
            elem_next[L_R00] = W'(ONE_Q);
            elem_next[L_R11] = W'(ONE_Q);
            elem_next[L_R22] = W'(ONE_Q);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            elem_reg <= elem_next;
            zero_reg <= zero_in;
        end
    end

endmodule
`default_nettype wire
